>>> src/ytb_pkg.sv
// Types, constants and helper functions for the YUY2 to BGR pixel pair converter.
`timescale 1ns / 1ps

package ytb_pkg;

	localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
	localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;
	localparam logic signed [9:0] LUMA_GAIN     = 10'sd298;
	localparam logic signed [9:0] RED_V_GAIN    = 10'sd459;
	localparam logic signed [9:0] GREEN_U_GAIN  = -10'sd137;
	localparam logic signed [9:0] GREEN_V_GAIN  = 10'sd55;
	localparam logic signed [10:0] BLUE_U_GAIN  = 11'sd541;
	localparam logic signed [17:0] TRUNC_BIAS   = 18'sd255;
	localparam logic signed [10:0] CHAN_MAX     = 11'sd255;
	localparam int unsigned FRAC_BITS           = 8;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] chroma_blue;
		logic [7:0] luma_second;
		logic [7:0] chroma_red;
	} ytb_pair_t;

	typedef struct packed {
		logic [7:0] blue_first;
		logic [7:0] green_first;
		logic [7:0] red_first;
		logic [7:0] blue_second;
		logic [7:0] green_second;
		logic [7:0] red_second;
	} ytb_bgr_t;

	// raw products
	typedef struct packed {
		logic signed [17:0] luma_first;
		logic signed [17:0] luma_second;
		logic signed [16:0] red;
		logic signed [15:0] green;
		logic signed [17:0] blue;
	} ytb_prod_t;

	// products scaled by 1/256
	typedef struct packed {
		logic signed [9:0] luma_first;
		logic signed [9:0] luma_second;
		logic signed [9:0] red;
		logic signed [9:0] green;
		logic signed [9:0] blue;
	} ytb_scaled_t;

	// divide by 256, truncating toward zero
	function automatic logic signed [9:0] div256_trunc(input logic signed [17:0] v);
		logic signed [17:0] t;
		t = v + (v[17] ? TRUNC_BIAS : 18'sd0);
		return 10'(t >>> FRAC_BITS);
	endfunction

	function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
		logic [7:0] r;
		if (v < 11'sd0) begin
			r = 8'd0;
		end else if (v > CHAN_MAX) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

>>> src/ytb_ifs.sv
// Valid/ready channel interfaces for pixel pair groups and BGR results.
`timescale 1ns / 1ps

interface ytb_pair_if
	import ytb_pkg::*;
();
	logic      valid;
	logic      ready;
	ytb_pair_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ytb_bgr_if
	import ytb_pkg::*;
();
	logic     valid;
	logic     ready;
	ytb_bgr_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/ytb_mult.sv
// Stage 1: centres luma and chroma and forms the weighted products.
`timescale 1ns / 1ps

module ytb_mult
	import ytb_pkg::*;
(
	input  logic      clk,
	input  logic      en,
	input  ytb_pair_t pair,
	output ytb_prod_t prod_s1
);

	logic signed [8:0] y0, y1, u, v;
	ytb_prod_t         prod;

	always_comb begin
		y0 = $signed({1'b0, pair.luma_first}) - LUMA_OFFSET;
		y1 = $signed({1'b0, pair.luma_second}) - LUMA_OFFSET;
		u  = $signed({1'b0, pair.chroma_blue}) - CHROMA_OFFSET;
		v  = $signed({1'b0, pair.chroma_red}) - CHROMA_OFFSET;
		prod.luma_first  = 18'(y0) * 18'(LUMA_GAIN);
		prod.luma_second = 18'(y1) * 18'(LUMA_GAIN);
		prod.red         = 17'(v) * 17'(RED_V_GAIN);
		prod.green       = 16'(u) * 16'(GREEN_U_GAIN) - 16'(v) * 16'(GREEN_V_GAIN);
		prod.blue        = 18'(u) * 18'(BLUE_U_GAIN);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
		end
	end

endmodule

>>> src/ytb_scale.sv
// Stage 2: scales each product by 1/256 with truncation toward zero.
`timescale 1ns / 1ps

module ytb_scale
	import ytb_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  ytb_prod_t   prod_s1,
	output ytb_scaled_t scaled_s2
);

	ytb_scaled_t scaled;

	always_comb begin
		scaled.luma_first  = div256_trunc(prod_s1.luma_first);
		scaled.luma_second = div256_trunc(prod_s1.luma_second);
		scaled.red         = div256_trunc(18'(prod_s1.red));
		scaled.green       = div256_trunc(18'(prod_s1.green));
		scaled.blue        = div256_trunc(prod_s1.blue);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s2 <= scaled;
		end
	end

endmodule

>>> src/ytb_mix.sv
// Stage 3: adds chroma offsets to each luma and clamps to a byte.
`timescale 1ns / 1ps

module ytb_mix
	import ytb_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  ytb_scaled_t scaled_s2,
	output ytb_bgr_t    bgr_s3
);

	ytb_bgr_t bgr;

	always_comb begin
		bgr.blue_first   = clamp_byte(11'(scaled_s2.luma_first) + 11'(scaled_s2.blue));
		bgr.green_first  = clamp_byte(11'(scaled_s2.luma_first) + 11'(scaled_s2.green));
		bgr.red_first    = clamp_byte(11'(scaled_s2.luma_first) + 11'(scaled_s2.red));
		bgr.blue_second  = clamp_byte(11'(scaled_s2.luma_second) + 11'(scaled_s2.blue));
		bgr.green_second = clamp_byte(11'(scaled_s2.luma_second) + 11'(scaled_s2.green));
		bgr.red_second   = clamp_byte(11'(scaled_s2.luma_second) + 11'(scaled_s2.red));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bgr_s3 <= bgr;
		end
	end

endmodule

>>> src/yuy2_to_bgr_pixel_pair_unit.sv
// Top level: three-stage YUY2 group to BGR24 pixel pair converter.
//
//   channel    dir  payload                                   handshake
//   pair_in    in   luma_first, chroma_blue, luma_second,     valid/ready
//                   chroma_red (8 bits each)
//   pixel_out  out  blue/green/red of first and second pixel  valid/ready
//                   (8 bits each)
//
// One transaction per cycle while pixel_out is ready; the stages are products, scaling, sum and clamp.
// Each stage holds while the one after it is full and stalled; no bubbles needed.
// Reset empties the pipeline; data registers are not reset.
`timescale 1ns / 1ps

module yuy2_to_bgr_pixel_pair_unit
	import ytb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ytb_pair_if.sink  pair_in,
	ytb_bgr_if.source pixel_out
);

	logic        valid_s1, valid_s2, valid_s3;
	logic        en1, en2, en3;
	ytb_prod_t   prod_s1;
	ytb_scaled_t scaled_s2;
	ytb_bgr_t    bgr_s3;

	assign en3 = !valid_s3 || pixel_out.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign pair_in.ready   = en1;
	assign pixel_out.valid = valid_s3;
	assign pixel_out.data  = bgr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= pair_in.valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	ytb_mult u_mult (
		.clk     (clk),
		.en      (en1),
		.pair    (pair_in.data),
		.prod_s1 (prod_s1)
	);

	ytb_scale u_scale (
		.clk       (clk),
		.en        (en2),
		.prod_s1   (prod_s1),
		.scaled_s2 (scaled_s2)
	);

	ytb_mix u_mix (
		.clk       (clk),
		.en        (en3),
		.scaled_s2 (scaled_s2),
		.bgr_s3    (bgr_s3)
	);

endmodule

>>> src/ytb_chk.sv
// Port-level checker for the pixel pair converter, bound to the top level.
`timescale 1ns / 1ps

module ytb_chk
	import ytb_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input ytb_bgr_t out_data
);

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// free-flowing output never back-pressures the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled with output ready");

	// accepted transaction appears at the output when the output stays ready throughout
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind yuy2_to_bgr_pixel_pair_unit ytb_chk u_ytb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pair_in.valid),
	.in_ready  (pair_in.ready),
	.out_valid (pixel_out.valid),
	.out_ready (pixel_out.ready),
	.out_data  (pixel_out.data)
);
